FILE: design/mmp_pkg.sv
// ----------------------------------------------------------------------------
// mmp_pkg
// Types, constants and helpers shared by the modular matrix power core.
// ----------------------------------------------------------------------------
`default_nettype none

package mmp_pkg;

    localparam int MAX_DIM    = 8;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int IDX_W      = $clog2(CELLS);
    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int VAL_W      = 31;
    localparam int EXP_W      = 63;
    localparam int SIZE_W     = 4;
    localparam int ADDR_W     = 3;

    localparam logic [VAL_W-1:0]  MOD_RESET  = VAL_W'(1000000007);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_SIZE    = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] elem_value;
        logic [EXP_W-1:0] exponent;
        logic             last_elem;
    } t_req;

    typedef struct packed {
        logic [DIM_W-1:0] out_row;
        logic [DIM_W-1:0] out_col;
        logic [VAL_W-1:0] out_value;
        logic             out_last;
    } t_res;

    function automatic logic [IDX_W-1:0] f_idx(input logic [DIM_W-1:0] row,
                                              input logic [DIM_W-1:0] col,
                                              input logic [SIZE_W-1:0] n);
        logic [IDX_W:0] t;
        t = (IDX_W+1)'(row) * (IDX_W+1)'(n) + (IDX_W+1)'(col);
        return t[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: design/modular_matrix_power_core.sv
// ----------------------------------------------------------------------------
// modular_matrix_power_core
// Loads a square matrix element by element and raises it to a power modulo a
// configurable modulus by square-and-multiply on one shared modular unit.
//
//  Channel   | Signals                          | Handshake
//  ----------+----------------------------------+------------------------------
//  request   | i_req (t_req)                    | taken when start & !busy
//  result    | o_res (t_res)                    | one cycle, strobed by o_valid
//  config    | psel penable pwrite paddr pwdata | APB, pready always high
//
// The shared unit is a bit-serial modular multiplier, MSB of the multiplier first.
// A request that loads an element reduces it through the unit and stores it. A
// last element adds a reduction pass over the matrix that also sets the
// accumulator to identity, then per exponent bit up to two matrix products,
// then the results. Reset is synchronous, active low; no clearing pass.
// The receiver cannot stall; results come out in row-major order with o_valid
// low between them, the last one in the cycle in which busy drops.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_matrix_power_core (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire mmp_pkg::t_req           i_req,
    output logic                         o_valid,
    output mmp_pkg::t_res                o_res,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [mmp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import mmp_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RUN    = 4'd1;
    localparam logic [3:0] S_LDDONE = 4'd2;
    localparam logic [3:0] S_CPRD   = 4'd3;
    localparam logic [3:0] S_CPLD   = 4'd4;
    localparam logic [3:0] S_CPDONE = 4'd5;
    localparam logic [3:0] S_NEXT   = 4'd6;
    localparam logic [3:0] S_MA     = 4'd7;
    localparam logic [3:0] S_MB     = 4'd8;
    localparam logic [3:0] S_MC     = 4'd9;
    localparam logic [3:0] S_MACC   = 4'd10;
    localparam logic [3:0] S_CSRD   = 4'd11;
    localparam logic [3:0] S_CSWR   = 4'd12;
    localparam logic [3:0] S_OUTRD  = 4'd13;
    localparam logic [3:0] S_OUTEM  = 4'd14;

    localparam logic [4:0] LAST_STEP = 5'(VAL_W - 1);

    logic [VAL_W-1:0]  r_modulus;
    logic [SIZE_W-1:0] r_msize;

    logic [3:0]        r_state, n_state, r_ret, n_ret;
    logic [DIM_W-1:0]  r_i, n_i, r_j, n_j, r_k, n_k;
    logic [4:0]        r_cnt, n_cnt;
    logic [VAL_W-1:0]  r_ua, n_ua, r_ub, n_ub, r_ur, n_ur, r_s, n_s;
    logic [EXP_W-1:0]  r_exp, n_exp;
    logic              r_phase, n_phase, r_sq, n_sq, r_last, n_last;
    logic [IDX_W:0]    r_lidx, n_lidx;
    logic              r_valid, n_valid;
    t_res              r_res, n_res;

    logic [VAL_W-1:0]  r_base [CELLS];
    logic [VAL_W-1:0]  r_pw   [CELLS];
    logic [VAL_W-1:0]  r_acc  [CELLS];
    logic [VAL_W-1:0]  r_scr  [CELLS];
    logic [VAL_W-1:0]  r_base_q, r_pw_q, r_acc_q, r_scr_q;

    logic [IDX_W-1:0]  base_ra, pw_ra, acc_ra, scr_ra;
    logic              base_we, pw_we, acc_we, scr_we;
    logic [IDX_W-1:0]  base_wa, pw_wa, acc_wa, scr_wa;
    logic [VAL_W-1:0]  base_wd, pw_wd, acc_wd, scr_wd;

    logic [SIZE_W-1:0] n_eff;
    logic [DIM_W-1:0]  nm1;
    logic [IDX_W:0]    cells;
    logic [VAL_W-1:0]  m_eff, one;
    logic [IDX_W-1:0]  idx_ij, idx_ik, idx_kj;
    logic              last_ij;
    logic [VAL_W+1:0]  st, st1, st2;
    logic [VAL_W:0]    sum, sum_m;
    logic              cfg_we;

    assign n_eff = (r_msize == '0) ? SIZE_W'(1) :
                   (r_msize > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r_msize;
    assign nm1   = DIM_W'(n_eff - SIZE_W'(1));
    assign cells = (IDX_W+1)'(n_eff) * (IDX_W+1)'(n_eff);
    assign m_eff = (r_modulus < VAL_W'(2)) ? VAL_W'(1) : r_modulus;
    assign one   = (m_eff == VAL_W'(1)) ? '0 : VAL_W'(1);

    assign idx_ij  = f_idx(r_i, r_j, n_eff);
    assign idx_ik  = f_idx(r_i, r_k, n_eff);
    assign idx_kj  = f_idx(r_k, r_j, n_eff);
    assign last_ij = (r_i == nm1) && (r_j == nm1);

    assign st  = {1'b0, r_ur, 1'b0} + (r_ub[VAL_W-1] ? (VAL_W+2)'(r_ua) : '0);
    assign st1 = (st >= (VAL_W+2)'(m_eff)) ? st - (VAL_W+2)'(m_eff) : st;
    assign st2 = (st1 >= (VAL_W+2)'(m_eff)) ? st1 - (VAL_W+2)'(m_eff) : st1;

    assign sum   = (VAL_W+1)'(r_s) + (VAL_W+1)'(r_ur);
    assign sum_m = (sum >= (VAL_W+1)'(m_eff)) ? sum - (VAL_W+1)'(m_eff) : sum;

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == REG_SIZE) ? {28'd0, r_msize} : {1'b0, r_modulus};

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_ua    = r_ua;
        n_ub    = r_ub;
        n_ur    = r_ur;
        n_s     = r_s;
        n_exp   = r_exp;
        n_phase = r_phase;
        n_sq    = r_sq;
        n_last  = r_last;
        n_lidx  = r_lidx;
        n_valid = 1'b0;
        n_res   = r_res;
        base_ra = idx_ij;
        pw_ra   = idx_ik;
        acc_ra  = idx_ij;
        scr_ra  = idx_ij;
        base_we = 1'b0;
        pw_we   = 1'b0;
        acc_we  = 1'b0;
        scr_we  = 1'b0;
        base_wa = r_lidx[IDX_W-1:0];
        pw_wa   = idx_ij;
        acc_wa  = idx_ij;
        scr_wa  = idx_ij;
        base_wd = r_ur;
        pw_wd   = r_ur;
        acc_wd  = (r_i == r_j) ? one : '0;
        scr_wd  = sum_m[VAL_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_exp  = i_req.exponent;
                    n_last = i_req.last_elem;
                    n_i    = '0;
                    n_j    = '0;
                    if (r_lidx < cells) begin
                        n_ua    = one;
                        n_ub    = i_req.elem_value;
                        n_ur    = '0;
                        n_cnt   = '0;
                        n_ret   = S_LDDONE;
                        n_state = S_RUN;
                    end else if (i_req.last_elem) begin
                        n_state = S_CPRD;
                    end
                end
            end
            S_RUN: begin
                n_ur  = st2[VAL_W-1:0];
                n_ub  = {r_ub[VAL_W-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == LAST_STEP) begin
                    n_state = r_ret;
                end
            end
            S_LDDONE: begin
                base_we = 1'b1;
                n_lidx  = r_lidx + (IDX_W+1)'(1);
                n_state = r_last ? S_CPRD : S_IDLE;
            end
            S_CPRD: begin
                n_state = S_CPLD;
            end
            S_CPLD: begin
                n_ua    = one;
                n_ub    = r_base_q;
                n_ur    = '0;
                n_cnt   = '0;
                n_ret   = S_CPDONE;
                n_state = S_RUN;
            end
            S_CPDONE: begin
                pw_we  = 1'b1;
                acc_we = 1'b1;
                if (last_ij) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_phase = 1'b0;
                    n_state = S_NEXT;
                end else begin
                    n_j     = (r_j == nm1) ? '0 : r_j + DIM_W'(1);
                    n_i     = (r_j == nm1) ? r_i + DIM_W'(1) : r_i;
                    n_state = S_CPRD;
                end
            end
            S_NEXT: begin
                n_i = '0;
                n_j = '0;
                n_k = '0;
                n_s = '0;
                if (r_exp == '0) begin
                    n_state = S_OUTRD;
                end else if (!r_phase && r_exp[0]) begin
                    n_sq    = 1'b0;
                    n_phase = 1'b1;
                    n_state = S_MA;
                end else begin
                    n_exp   = r_exp >> 1;
                    n_phase = 1'b0;
                    n_sq    = 1'b1;
                    n_state = (r_exp[EXP_W-1:1] != '0) ? S_MA : S_OUTRD;
                end
            end
            S_MA: begin
                pw_ra   = idx_ik;
                n_state = S_MB;
            end
            S_MB: begin
                n_ua    = r_pw_q;
                pw_ra   = idx_kj;
                acc_ra  = idx_kj;
                n_state = S_MC;
            end
            S_MC: begin
                n_ub    = r_sq ? r_pw_q : r_acc_q;
                n_ur    = '0;
                n_cnt   = '0;
                n_ret   = S_MACC;
                n_state = S_RUN;
            end
            S_MACC: begin
                if (r_k == nm1) begin
                    scr_we = 1'b1;
                    n_s    = '0;
                    n_k    = '0;
                    if (last_ij) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_state = S_CSRD;
                    end else begin
                        n_j     = (r_j == nm1) ? '0 : r_j + DIM_W'(1);
                        n_i     = (r_j == nm1) ? r_i + DIM_W'(1) : r_i;
                        n_state = S_MA;
                    end
                end else begin
                    n_s     = sum_m[VAL_W-1:0];
                    n_k     = r_k + DIM_W'(1);
                    n_state = S_MA;
                end
            end
            S_CSRD: begin
                n_state = S_CSWR;
            end
            S_CSWR: begin
                pw_wd  = r_scr_q;
                acc_wd = r_scr_q;
                pw_we  = r_sq;
                acc_we = !r_sq;
                if (last_ij) begin
                    n_state = S_NEXT;
                end else begin
                    n_j     = (r_j == nm1) ? '0 : r_j + DIM_W'(1);
                    n_i     = (r_j == nm1) ? r_i + DIM_W'(1) : r_i;
                    n_state = S_CSRD;
                end
            end
            S_OUTRD: begin
                n_state = S_OUTEM;
            end
            S_OUTEM: begin
                n_valid         = 1'b1;
                n_res.out_row   = r_i;
                n_res.out_col   = r_j;
                n_res.out_value = r_acc_q;
                n_res.out_last  = last_ij;
                if (last_ij) begin
                    n_lidx  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_j     = (r_j == nm1) ? '0 : r_j + DIM_W'(1);
                    n_i     = (r_j == nm1) ? r_i + DIM_W'(1) : r_i;
                    n_state = S_OUTRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_lidx    <= '0;
            r_valid   <= 1'b0;
            r_phase   <= 1'b0;
            r_modulus <= MOD_RESET;
            r_msize   <= SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_lidx  <= n_lidx;
            r_valid <= n_valid;
            r_phase <= n_phase;
            if (cfg_we) begin
                if (paddr[2] == REG_MODULUS) begin
                    r_modulus <= pwdata[VAL_W-1:0];
                end else begin
                    r_msize <= pwdata[SIZE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_cnt  <= n_cnt;
        r_ua   <= n_ua;
        r_ub   <= n_ub;
        r_ur   <= n_ur;
        r_s    <= n_s;
        r_exp  <= n_exp;
        r_sq   <= n_sq;
        r_last <= n_last;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (base_we) begin
            r_base[base_wa] <= base_wd;
        end
        if (pw_we) begin
            r_pw[pw_wa] <= pw_wd;
        end
        if (acc_we) begin
            r_acc[acc_wa] <= acc_wd;
        end
        if (scr_we) begin
            r_scr[scr_wa] <= scr_wd;
        end
        r_base_q <= r_base[base_ra];
        r_pw_q   <= r_pw[pw_ra];
        r_acc_q  <= r_acc[acc_ra];
        r_scr_q  <= r_scr[scr_ra];
    end

endmodule

`default_nettype wire
